// ===== hdl/fpw_pkg.sv =====
// shared constants, codes and types of the four-level page table walker
`default_nettype none
package fpw_pkg;
    localparam int TABLE_PAGES = 16;
    localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int IDX_W       = 9;
    localparam int ADDR_W      = PAGE_W + IDX_W;
    localparam int NFP_W       = $clog2(TABLE_PAGES + 1);
    localparam int FRAME_W     = 40;

    localparam logic [1:0] ACT_MAP       = 2'd0;
    localparam logic [1:0] ACT_UNMAP     = 2'd1;
    localparam logic [1:0] ACT_TRANSLATE = 2'd2;
    localparam logic [1:0] ACT_NONE      = 2'd3;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_ABSENT   = 2'd1;
    localparam logic [1:0] ST_EXHAUSTED = 2'd2;

    localparam logic [2:0] CK_WC = 3'd2;
    localparam logic [2:0] CK_WT = 3'd3;
    localparam logic [2:0] CK_UC = 3'd4;

    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_RD   = 6'b000100,
        S_CHK  = 6'b001000,
        S_LINK = 6'b010000,
        S_DONE = 6'b100000
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/fpw_ram.sv =====
// single-port table store with registered read data
`default_nettype none
module fpw_ram (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [fpw_pkg::ADDR_W-1:0] i_addr,
    input  wire logic [63:0]               i_wdata,
    output logic      [63:0]               o_rdata
);
    import fpw_pkg::*;

    logic [63:0] r_mem [TABLE_PAGES*512];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hdl/four_level_page_table_walker.sv =====
// four-level page table walker: control sequencer around the table store
// each level passes through S_RD and S_CHK; S_DONE registers the result
// each table page created by map adds a zeroing sweep over its 512 entries and one link write
// one item at a time, each walking up to four dependent reads through the store port
// reset: synchronous; afterwards a clearing pass over all TABLE_PAGES*512 entries (8192) zeroes the
// store while no item is taken; table_base resets to 0 and the allocator to page 1
`default_nettype none
module four_level_page_table_walker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [51:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_action,
    input  wire logic [47:0] i_virt_addr,
    input  wire logic [51:0] i_phys_addr,
    input  wire logic        i_flag_present,
    input  wire logic        i_flag_writeable,
    input  wire logic        i_flag_user,
    input  wire logic        i_flag_global,
    input  wire logic        i_flag_no_execute,
    input  wire logic [2:0]  i_cache_kind,
    input  wire logic [3:0]  i_protection_key,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [51:0]      o_phys_frame,
    output logic             o_invalidate_hint
);
    import fpw_pkg::*;

    t_state r_state, n_state;
    logic [FRAME_W-1:0] r_base;
    logic [NFP_W-1:0]   r_nfp, n_nfp;
    logic [ADDR_W-1:0]  r_caddr, n_caddr, r_cend, n_cend, r_slot, n_slot;
    logic [PAGE_W-1:0]  r_page, n_page, r_np, n_np;
    logic [1:0]         r_level, n_level;
    logic               r_boot, n_boot;
    logic               r_ovalid, n_ovalid;
    logic [1:0]         r_st, n_st;
    logic [51:0]        r_frame, n_frame;
    logic               r_hint, n_hint;
    logic [1:0]         r_ost;
    logic [51:0]        r_oframe;
    logic               r_ohint;

    logic [1:0]  r_act;
    logic [47:0] r_va;
    logic [63:0] r_leaf;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [63:0]       ram_wdata, ram_rdata;

    logic [IDX_W-1:0]   idx;
    logic [FRAME_W-1:0] off;
    logic [FRAME_W-1:0] link_frame;
    logic [63:0]        leaf_e;
    logic               accept;

    fpw_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign o_in_stall        = (r_state != S_IDLE);
    assign accept            = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid       = r_ovalid;
    assign o_status          = r_ost;
    assign o_phys_frame      = r_oframe;
    assign o_invalidate_hint = r_ohint;

    always_comb begin
        case (r_level)
            2'd0:    idx = r_va[47:39];
            2'd1:    idx = r_va[38:30];
            2'd2:    idx = r_va[29:21];
            default: idx = r_va[20:12];
        endcase
    end

    assign off        = ram_rdata[51:12] - r_base;
    assign link_frame = r_base + FRAME_W'(r_np);

    // leaf entry assembled at accept
    always_comb begin
        leaf_e        = '0;
        leaf_e[51:12] = i_phys_addr[51:12];
        leaf_e[0]     = i_flag_present;
        leaf_e[1]     = i_flag_writeable;
        leaf_e[2]     = i_flag_user;
        leaf_e[8]     = i_flag_global;
        leaf_e[63]    = i_flag_no_execute;
        leaf_e[3]     = (i_cache_kind == CK_WC) || (i_cache_kind == CK_UC);
        leaf_e[4]     = (i_cache_kind == CK_WT);
        leaf_e[7]     = (i_cache_kind == CK_UC);
        leaf_e[62:59] = i_protection_key;
    end

    always_comb begin
        n_state  = r_state;
        n_nfp    = r_nfp;
        n_caddr  = r_caddr;
        n_cend   = r_cend;
        n_slot   = r_slot;
        n_page   = r_page;
        n_np     = r_np;
        n_level  = r_level;
        n_boot   = r_boot;
        n_st     = r_st;
        n_frame  = r_frame;
        n_hint   = r_hint;
        n_ovalid = r_ovalid && i_out_stall;
        ram_we    = 1'b0;
        ram_addr  = r_slot;
        ram_wdata = '0;
        case (r_state)
            S_CLR: begin
                ram_we   = 1'b1;
                ram_addr = r_caddr;
                n_caddr  = r_caddr + 1'b1;
                if (r_caddr == r_cend) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_LINK;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_level = '0;
                    n_page  = '0;
                    n_st    = ST_DONE;
                    n_frame = '0;
                    n_hint  = 1'b0;
                    n_state = (i_action == ACT_NONE) ? S_DONE : S_RD;
                end
            end
            S_RD: begin
                ram_addr = {r_page, idx};
                n_slot   = {r_page, idx};
                n_state  = S_CHK;
            end
            S_CHK: begin
                n_state = S_DONE;
                if (r_level == LVL_LEAF) begin
                    case (r_act)
                        ACT_MAP: begin
                            ram_we    = 1'b1;
                            ram_wdata = r_leaf;
                        end
                        ACT_UNMAP: begin
                            ram_we = 1'b1;
                            n_hint = 1'b1;
                        end
                        default: begin
                            if (ram_rdata[0]) begin
                                n_frame = {ram_rdata[51:12], 12'h000};
                            end else begin
                                n_st = ST_ABSENT;
                            end
                        end
                    endcase
                end else if (ram_rdata[0]) begin
                    // link must land on a page of the store
                    if (off >= FRAME_W'(TABLE_PAGES)) begin
                        n_st = ST_ABSENT;
                    end else begin
                        n_page  = off[PAGE_W-1:0];
                        n_level = r_level + 1'b1;
                        n_state = S_RD;
                    end
                end else if (r_act != ACT_MAP) begin
                    n_st = ST_ABSENT;
                end else if (r_nfp >= NFP_W'(TABLE_PAGES)) begin
                    n_st = ST_EXHAUSTED;
                end else begin
                    n_np    = r_nfp[PAGE_W-1:0];
                    n_nfp   = r_nfp + 1'b1;
                    n_caddr = {r_nfp[PAGE_W-1:0], {IDX_W{1'b0}}};
                    n_cend  = {r_nfp[PAGE_W-1:0], {IDX_W{1'b1}}};
                    n_state = S_CLR;
                end
            end
            S_LINK: begin
                ram_we    = 1'b1;
                ram_wdata = {12'h000, link_frame, 12'h007};
                n_page    = r_np;
                n_level   = r_level + 1'b1;
                n_state   = S_RD;
            end
            S_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_base   <= '0;
            r_nfp    <= NFP_W'(1);
            r_caddr  <= '0;
            r_cend   <= '1;
            r_boot   <= 1'b1;
            r_ovalid <= 1'b0;
            r_level  <= '0;
        end else begin
            r_state  <= n_state;
            r_nfp    <= n_nfp;
            r_caddr  <= n_caddr;
            r_cend   <= n_cend;
            r_boot   <= n_boot;
            r_ovalid <= n_ovalid;
            r_level  <= n_level;
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata[51:12];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_page  <= n_page;
        r_np    <= n_np;
        r_st    <= n_st;
        r_frame <= n_frame;
        r_hint  <= n_hint;
        if (accept) begin
            r_act  <= i_action;
            r_va   <= i_virt_addr;
            r_leaf <= leaf_e;
        end
        if (r_state == S_DONE && (!r_ovalid || !i_out_stall)) begin
            r_ost    <= r_st;
            r_oframe <= r_frame;
            r_ohint  <= r_hint;
        end
    end
endmodule
`default_nettype wire

// ===== hdl/fpw_checker.sv =====
// port-level checks for the page table walker, bound to the top level
`default_nettype none
module fpw_props (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic [1:0]  o_status,
    input wire logic [51:0] o_phys_frame,
    input wire logic        o_invalidate_hint
);
    import fpw_pkg::*;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_EXHAUSTED))
        else $error("status code out of range");

    a_hint_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_invalidate_hint) |-> (o_status == ST_DONE && o_phys_frame == '0))
        else $error("invalidate on a failed or translating item");

    a_frame_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_phys_frame != '0) |-> (o_status == ST_DONE
            && o_phys_frame[11:0] == 12'h000))
        else $error("frame on a failed item or unaligned");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_status)
            && $stable(o_phys_frame) && $stable(o_invalidate_hint)))
        else $error("stalled result changed");
endmodule

bind four_level_page_table_walker fpw_props u_fpw_props (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_phys_frame      (o_phys_frame),
    .o_invalidate_hint (o_invalidate_hint)
);
`default_nettype wire
